### hw/rtl/nus_pkg.sv
package nus_pkg;

  localparam int MaxEm     = 8;
  localparam int MaxBands  = 16;
  localparam int EmW       = $clog2(MaxEm);
  localparam int BandW     = $clog2(MaxBands);
  localparam int SmpW      = 16;
  localparam int FracW     = 16;
  localparam int FracBits  = 12;
  localparam int GramW     = 40;
  localparam int GradW     = 48;
  localparam int AccW      = 48;
  localparam int MulAW     = 25;
  localparam int MulBW     = 41;
  localparam int ProdW     = MulAW + MulBW;
  localparam int DivNW     = 61;
  localparam int DivDW     = GramW;
  localparam int DivSteps  = DivNW - 1;
  localparam int DivCntW   = $clog2(DivSteps + 1);
  localparam int SqW       = 56;
  localparam int MagW      = 24;
  localparam int TolW      = 15;
  localparam int LimitW    = 16;
  localparam int NemCfgW   = 4;
  localparam int NbCfgW    = 5;

  localparam logic [LimitW-1:0]  LimitRst = 16'd400;
  localparam logic [TolW-1:0]    TolRst   = '0;
  localparam logic [NemCfgW-1:0] NemRst   = 4'd8;
  localparam logic [NbCfgW-1:0]  NbRst    = 5'd16;

  typedef enum logic [1:0] {
    CFG_LIMIT = 2'd0,
    CFG_TOL   = 2'd1,
    CFG_NEM   = 2'd2,
    CFG_NB    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_e;

  typedef enum logic {
    RES_FRAC = 1'b0,
    RES_RMSE = 1'b1
  } res_kind_e;

  typedef logic signed [MulAW-1:0] mul_a_t;
  typedef logic signed [MulBW-1:0] mul_b_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [GradW-1:0] grad_t;
  typedef logic signed [DivNW-1:0] quot_t;

  typedef struct packed {
    logic                   mode;
    logic [EmW-1:0]         endmember_index;
    logic [BandW-1:0]       band_index;
    logic signed [SmpW-1:0] sample_value;
  } nus_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [EmW-1:0]   result_index;
    logic [FracW-1:0] result_value;
    logic             last_of_pixel;
  } nus_out_t;

  typedef struct packed {
    logic             start;
    quot_t            num;
    logic [DivDW-1:0] den;
  } nus_div_req_t;

  typedef struct packed {
    logic  done;
    quot_t quot;
  } nus_div_rsp_t;

endpackage

### hw/rtl/nus_ram.sv
module nus_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/nus_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Divisor is taken as positive.
module nus_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nus_pkg::nus_div_req_t req_i,
  output nus_pkg::nus_div_rsp_t rsp_o
);

  logic [nus_pkg::DivNW-2:0]   mag_q, mag_d;
  logic [nus_pkg::DivDW-1:0]   rem_q, rem_d, den_q;
  logic [nus_pkg::DivDW:0]     rem_sh;
  logic [nus_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        neg_q, done_q, done_d, ge;
  nus_pkg::quot_t              num_abs;

  assign num_abs = req_i.num[nus_pkg::DivNW-1] ? -req_i.num : req_i.num;
  assign rem_sh  = {rem_q, mag_q[nus_pkg::DivNW-2]};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (cnt_q != '0) begin
      rem_d = ge ? nus_pkg::DivDW'(rem_sh - {1'b0, den_q})
                 : rem_sh[nus_pkg::DivDW-1:0];
      mag_d = {mag_q[nus_pkg::DivNW-3:0], ge};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == nus_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= req_i.start ? nus_pkg::DivCntW'(nus_pkg::DivSteps) : cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= num_abs[nus_pkg::DivNW-2:0];
      rem_q <= '0;
      den_q <= req_i.den;
      neg_q <= req_i.num[nus_pkg::DivNW-1];
    end else begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

### hw/rtl/nnls_unmixing_solver.sv
// Per-pixel nonnegative least-squares unmixing. Mode-0 beats load endmember
// coefficients; mode-1 beats load pixel band samples. The mode-1 beat for
// the last band in use starts a solve: busy_o rises and start_i is ignored
// until all results are out. A solve, with E endmembers and B bands, runs
//   Gram and correlation (one shared multiplier, one RAM port), then S sweeps,
//   at most the limit (per coordinate a serial division, and a gradient update
//   over all E entries when the fraction moves; a zero diagonal skips the
//   divider), then the residual, mean division and 28-step square root.
// Load beats leave the block idle. Results come as E fraction beats then one RMSE
// beat with last_of_pixel set, one per cycle on res_valid_o; the receiver
// cannot stall them. Config writes are always ready and are meant for idle.
module nnls_unmixing_solver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  nus_pkg::nus_in_t  in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              res_valid_o,
  output nus_pkg::nus_out_t res_o
);

  typedef enum logic [24:0] {
    S_IDLE  = 25'h0000001,
    S_G_RA  = 25'h0000002,
    S_G_RB  = 25'h0000004,
    S_G_MUL = 25'h0000008,
    S_G_ACC = 25'h0000010,
    S_C_RA  = 25'h0000020,
    S_C_MUL = 25'h0000040,
    S_C_ACC = 25'h0000080,
    S_D_CHK = 25'h0000100,
    S_D_RD  = 25'h0000200,
    S_D_DG  = 25'h0000400,
    S_D_DIV = 25'h0000800,
    S_U_RD  = 25'h0001000,
    S_U_MUL = 25'h0002000,
    S_U_ACC = 25'h0004000,
    S_R_RA  = 25'h0008000,
    S_R_MUL = 25'h0010000,
    S_R_ACC = 25'h0020000,
    S_R_DIF = 25'h0040000,
    S_R_SQ  = 25'h0080000,
    S_R_SUM = 25'h0100000,
    S_M_DIV = 25'h0200000,
    S_SQRT  = 25'h0400000,
    S_OUT_F = 25'h0800000,
    S_OUT_R = 25'h1000000
  } state_e;

  localparam int EmW   = nus_pkg::EmW;
  localparam int BandW = nus_pkg::BandW;
  localparam int SqW   = nus_pkg::SqW;

  state_e state_q, state_d;

  // configuration
  logic [nus_pkg::LimitW-1:0]  limit_q;
  logic [nus_pkg::TolW-1:0]    tol_q;
  logic [nus_pkg::NemCfgW-1:0] nem_cfg_q;
  logic [nus_pkg::NbCfgW-1:0]  nb_cfg_q;
  logic [EmW-1:0]              nem_m1;
  logic [BandW-1:0]            nb_m1;

  // sequencer counters and datapath registers
  logic [EmW-1:0]             i_q, i_d, j_q, j_d;
  logic [BandW-1:0]           b_q, b_d;
  logic [nus_pkg::LimitW-1:0] sweep_q, sweep_d;
  logic [nus_pkg::FracW-1:0]  maxd_q, maxd_d;
  nus_pkg::acc_t              acc_q, acc_d;
  logic signed [nus_pkg::SmpW-1:0] a_q, a_d;
  logic signed [nus_pkg::FracW:0]  delta_q, delta_d;
  logic [SqW-1:0]             sum_q, sum_d, v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [nus_pkg::MagW-1:0]   mag_q, mag_d;
  nus_pkg::grad_t             grad_q [nus_pkg::MaxEm];
  nus_pkg::grad_t             grad_d [nus_pkg::MaxEm];
  logic [nus_pkg::FracW-1:0]  frac_q [nus_pkg::MaxEm];
  logic [nus_pkg::FracW-1:0]  frac_d [nus_pkg::MaxEm];
  logic signed [nus_pkg::SmpW-1:0] pix_q [nus_pkg::MaxBands];

  // shared multiplier
  nus_pkg::mul_a_t mul_a;
  nus_pkg::mul_b_t mul_b;
  nus_pkg::prod_t  prod_q;

  // memories
  logic                         em_we, gram_we;
  logic [EmW+BandW-1:0]         em_addr;
  logic [2*EmW-1:0]             gram_addr;
  logic [nus_pkg::SmpW-1:0]     em_rdata;
  logic [nus_pkg::GramW-1:0]    gram_wdata, gram_rdata;

  nus_pkg::nus_div_req_t div_req;
  nus_pkg::nus_div_rsp_t div_rsp;

  // scratch
  logic signed [nus_pkg::DivNW:0] t_full;
  logic [nus_pkg::FracW-1:0]      t_cl, dabs;
  logic signed [nus_pkg::FracW:0] delta_w;
  nus_pkg::prod_t                 ptr;
  logic signed [nus_pkg::GradW+1:0] gsum;
  nus_pkg::acc_t                  diff, dmag, drnd;
  logic [SqW-1:0]                 sq_t;
  logic                           next_k, pix_acc;

  assign nem_m1 = (nem_cfg_q == '0) ? '0 :
                  (nem_cfg_q > nus_pkg::NemCfgW'(nus_pkg::MaxEm)) ? EmW'(nus_pkg::MaxEm - 1)
                  : EmW'(nem_cfg_q - 1'b1);
  assign nb_m1  = (nb_cfg_q == '0) ? '0 :
                  (nb_cfg_q > nus_pkg::NbCfgW'(nus_pkg::MaxBands))
                  ? BandW'(nus_pkg::MaxBands - 1) : BandW'(nb_cfg_q - 1'b1);

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign pix_acc     = start_i && !busy_o && (in_i.mode == nus_pkg::MODE_PIXEL);

  nus_ram #(.Width(nus_pkg::SmpW), .Depth(nus_pkg::MaxEm * nus_pkg::MaxBands)) u_em_ram (
    .clk_i   (clk_i),
    .we_i    (em_we),
    .addr_i  (em_addr),
    .wdata_i (in_i.sample_value),
    .rdata_o (em_rdata)
  );

  nus_ram #(.Width(nus_pkg::GramW), .Depth(nus_pkg::MaxEm * nus_pkg::MaxEm)) u_gram_ram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .addr_i  (gram_addr),
    .wdata_i (gram_wdata),
    .rdata_o (gram_rdata)
  );

  nus_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // coordinate update from the quotient: clamp to [0, 65535]
  always_comb begin
    t_full  = $signed({{(nus_pkg::DivNW + 1 - nus_pkg::FracW){1'b0}}, frac_q[i_q]})
              - $signed({div_rsp.quot[nus_pkg::DivNW-1], div_rsp.quot});
    if (t_full < 0) begin
      t_cl = '0;
    end else if (t_full > $signed({{(nus_pkg::DivNW + 1 - nus_pkg::FracW){1'b0}},
                                   {nus_pkg::FracW{1'b1}}})) begin
      t_cl = '1;
    end else begin
      t_cl = t_full[nus_pkg::FracW-1:0];
    end
    delta_w = $signed({1'b0, t_cl}) - $signed({1'b0, frac_q[i_q]});
    dabs    = delta_w[nus_pkg::FracW] ? nus_pkg::FracW'(-delta_w)
                                      : delta_w[nus_pkg::FracW-1:0];
  end

  // gradient update term, truncated toward zero, saturated to 48 bits
  always_comb begin
    ptr  = prod_q[nus_pkg::ProdW-1] ? (prod_q + nus_pkg::ProdW'(4095)) >>> nus_pkg::FracBits
                                    : prod_q >>> nus_pkg::FracBits;
    gsum = $signed({{2{grad_q[j_q][nus_pkg::GradW-1]}}, grad_q[j_q]})
           + ptr[nus_pkg::GradW+1:0];
  end

  // residual magnitude rounded half away from zero to an integer (Q24.0)
  always_comb begin
    diff = acc_q - (nus_pkg::acc_t'(pix_q[b_q]) <<< nus_pkg::FracBits);
    dmag = diff[nus_pkg::AccW-1] ? -diff : diff;
    drnd = (dmag + nus_pkg::AccW'(2048)) >> nus_pkg::FracBits;
    sq_t = res_q + bit_q;
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; b_d = b_q;
    sweep_d = sweep_q; maxd_d = maxd_q; acc_d = acc_q; a_d = a_q;
    delta_d = delta_q; sum_d = sum_q; v_d = v_q; res_d = res_q; bit_d = bit_q;
    mag_d = mag_q;
    grad_d = grad_q; frac_d = frac_q;
    em_we = 1'b0; em_addr = {i_q, b_q};
    gram_we = 1'b0; gram_addr = {i_q, j_q}; gram_wdata = acc_q[nus_pkg::GramW-1:0];
    mul_a = nus_pkg::mul_a_t'($signed(em_rdata));
    mul_b = nus_pkg::mul_b_t'($signed(em_rdata));
    div_req.start = 1'b0;
    div_req.num   = nus_pkg::quot_t'($signed({grad_q[i_q], {nus_pkg::FracBits{1'b0}}}));
    div_req.den   = gram_rdata;
    next_k = 1'b0;
    res_valid_o = 1'b0;
    res_o.result_kind   = nus_pkg::RES_FRAC;
    res_o.result_index  = i_q;
    res_o.result_value  = frac_q[i_q];
    res_o.last_of_pixel = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (in_i.mode == nus_pkg::MODE_LOAD) begin
            em_we   = 1'b1;
            em_addr = {in_i.endmember_index, in_i.band_index};
          end else if (in_i.band_index == nb_m1) begin
            i_d = '0; j_d = '0; b_d = '0; acc_d = '0; sweep_d = '0;
            state_d = S_G_RA;
          end
        end
      end
      // Gram matrix: G[i][j] = sum_b E[i][b]*E[j][b]
      S_G_RA: state_d = S_G_RB;
      S_G_RB: begin
        a_d = $signed(em_rdata);
        em_addr = {j_q, b_q};
        state_d = S_G_MUL;
      end
      S_G_MUL: begin
        mul_a = nus_pkg::mul_a_t'(a_q);
        state_d = S_G_ACC;
      end
      S_G_ACC: begin
        acc_d = acc_q + nus_pkg::acc_t'(prod_q);
        state_d = S_G_RA;
        if (b_q == nb_m1) begin
          gram_we    = 1'b1;
          gram_wdata = acc_d[nus_pkg::GramW-1:0];
          acc_d = '0;
          b_d = '0;
          if (j_q == nem_m1) begin
            j_d = '0;
            if (i_q == nem_m1) begin
              i_d = '0;
              state_d = S_C_RA;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      // negative correlation: g[i] = -sum_b E[i][b]*p[b]
      S_C_RA: state_d = S_C_MUL;
      S_C_MUL: begin
        mul_b = nus_pkg::mul_b_t'(pix_q[b_q]);
        state_d = S_C_ACC;
      end
      S_C_ACC: begin
        acc_d = acc_q + nus_pkg::acc_t'(prod_q);
        state_d = S_C_RA;
        if (b_q == nb_m1) begin
          grad_d[i_q] = -acc_d;
          frac_d[i_q] = '0;
          acc_d = '0;
          b_d = '0;
          if (i_q == nem_m1) begin
            i_d = '0;
            state_d = S_D_CHK;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      // sweep loop
      S_D_CHK: begin
        i_d = '0;
        if (sweep_q >= limit_q) begin
          b_d = '0; acc_d = '0; sum_d = '0;
          state_d = S_R_RA;
        end else begin
          maxd_d = '0;
          state_d = S_D_RD;
        end
      end
      S_D_RD: begin
        gram_addr = {i_q, i_q};
        state_d = S_D_DG;
      end
      S_D_DG: begin
        if (gram_rdata[nus_pkg::GramW-1] || gram_rdata == '0) begin
          next_k = 1'b1;   // nonpositive diagonal: coordinate skipped
        end else begin
          div_req.start = 1'b1;
          state_d = S_D_DIV;
        end
      end
      S_D_DIV: begin
        if (div_rsp.done) begin
          frac_d[i_q] = t_cl;
          delta_d = delta_w;
          if (dabs > maxd_q) begin
            maxd_d = dabs;
          end
          if (delta_w != '0) begin
            j_d = '0;
            state_d = S_U_RD;
          end else begin
            next_k = 1'b1;
          end
        end
      end
      S_U_RD: state_d = S_U_MUL;
      S_U_MUL: begin
        mul_a = nus_pkg::mul_a_t'(delta_q);
        mul_b = nus_pkg::mul_b_t'($signed(gram_rdata));
        state_d = S_U_ACC;
      end
      S_U_ACC: begin
        if (gsum[nus_pkg::GradW+1:nus_pkg::GradW-1] == '0 ||
            gsum[nus_pkg::GradW+1:nus_pkg::GradW-1] == '1) begin
          grad_d[j_q] = gsum[nus_pkg::GradW-1:0];
        end else begin
          grad_d[j_q] = {gsum[nus_pkg::GradW+1], {(nus_pkg::GradW-1){~gsum[nus_pkg::GradW+1]}}};
        end
        if (j_q == nem_m1) begin
          next_k = 1'b1;
        end else begin
          j_d = j_q + 1'b1;
          state_d = S_U_RD;
        end
      end
      // residual: pred[b] = sum_i f[i]*E[i][b]
      S_R_RA: state_d = S_R_MUL;
      S_R_MUL: begin
        mul_a = nus_pkg::mul_a_t'({1'b0, frac_q[i_q]});
        state_d = S_R_ACC;
      end
      S_R_ACC: begin
        acc_d = acc_q + nus_pkg::acc_t'(prod_q);
        if (i_q == nem_m1) begin
          i_d = '0;
          state_d = S_R_DIF;
        end else begin
          i_d = i_q + 1'b1;
          state_d = S_R_RA;
        end
      end
      S_R_DIF: begin
        mag_d = drnd[nus_pkg::MagW-1:0];
        acc_d = '0;
        state_d = S_R_SQ;
      end
      S_R_SQ: begin
        mul_a = nus_pkg::mul_a_t'({1'b0, mag_q});
        mul_b = nus_pkg::mul_b_t'({1'b0, mag_q});
        state_d = S_R_SUM;
      end
      S_R_SUM: begin
        sum_d = sum_q + prod_q[SqW-1:0];
        if (b_q == nb_m1) begin
          div_req.start = 1'b1;
          div_req.num   = nus_pkg::quot_t'(sum_d);
          div_req.den   = nus_pkg::DivDW'({1'b0, nb_m1} + 1'b1);
          state_d = S_M_DIV;
        end else begin
          b_d = b_q + 1'b1;
          state_d = S_R_RA;
        end
      end
      S_M_DIV: begin
        if (div_rsp.done) begin
          v_d   = div_rsp.quot[SqW-1:0];
          res_d = '0;
          bit_d = SqW'(1) << (SqW - 2);
          state_d = S_SQRT;
        end
      end
      // integer square root, two radicand bits per step
      S_SQRT: begin
        if (v_q >= sq_t) begin
          v_d   = v_q - sq_t;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == SqW'(1)) begin
          i_d = '0;
          state_d = S_OUT_F;
        end
      end
      S_OUT_F: begin
        res_valid_o = 1'b1;
        if (i_q == nem_m1) begin
          state_d = S_OUT_R;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_OUT_R: begin
        res_valid_o = 1'b1;
        res_o.result_kind   = nus_pkg::RES_RMSE;
        res_o.result_index  = '0;
        res_o.result_value  = (res_q > SqW'({nus_pkg::FracW{1'b1}})) ? '1
                              : res_q[nus_pkg::FracW-1:0];
        res_o.last_of_pixel = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // end of one coordinate; end of sweep checks the tolerance
    if (next_k) begin
      if (i_q == nem_m1) begin
        sweep_d = sweep_q + 1'b1;
        i_d = '0;
        if (maxd_q <= {1'b0, tol_q}) begin
          b_d = '0; acc_d = '0; sum_d = '0;
          state_d = S_R_RA;
        end else begin
          state_d = S_D_CHK;
        end
      end else begin
        i_d = i_q + 1'b1;
        state_d = S_D_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= nus_pkg::LimitRst;
      tol_q     <= nus_pkg::TolRst;
      nem_cfg_q <= nus_pkg::NemRst;
      nb_cfg_q  <= nus_pkg::NbRst;
      sweep_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      b_q       <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      i_q     <= i_d;
      j_q     <= j_d;
      b_q     <= b_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          nus_pkg::CFG_LIMIT: limit_q   <= cfg_data_i;
          nus_pkg::CFG_TOL:   tol_q     <= cfg_data_i[nus_pkg::TolW-1:0];
          nus_pkg::CFG_NEM:   nem_cfg_q <= cfg_data_i[nus_pkg::NemCfgW-1:0];
          nus_pkg::CFG_NB:    nb_cfg_q  <= cfg_data_i[nus_pkg::NbCfgW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    acc_q   <= acc_d;
    a_q     <= a_d;
    delta_q <= delta_d;
    maxd_q  <= maxd_d;
    sum_q   <= sum_d;
    mag_q   <= mag_d;
    v_q     <= v_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    grad_q  <= grad_d;
    frac_q  <= frac_d;
    if (pix_acc) begin
      pix_q[in_i.band_index] <= in_i.sample_value;
    end
  end

endmodule

### tb/tb_nnls_unmixing_solver.sv
`timescale 1ns / 100ps

module tb_nnls_unmixing_solver;

  localparam int CycleLimit = 4_000_000;
  localparam int MaxErrShown = 10;
  localparam longint GradHi = 64'sd140737488355327;
  localparam longint GradLo = -GradHi - 1;
  localparam int MaxEm = nus_pkg::MaxEm;
  localparam int MaxBands = nus_pkg::MaxBands;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  nus_pkg::nus_in_t in_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic res_valid_o;
  nus_pkg::nus_out_t res_o;

  nnls_unmixing_solver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow solver: own copy of stores and registers, updated on accepted beats
  // ---------------------------------------------------------------------------
  logic [nus_pkg::LimitW-1:0]  sh_limit = nus_pkg::LimitRst;
  logic [nus_pkg::TolW-1:0]    sh_tol   = nus_pkg::TolRst;
  logic [nus_pkg::NemCfgW-1:0] sh_nem   = nus_pkg::NemRst;
  logic [nus_pkg::NbCfgW-1:0]  sh_nb    = nus_pkg::NbRst;

  longint sh_coef [MaxEm*MaxBands];
  longint sh_pix  [MaxBands];
  longint sh_gram [MaxEm][MaxEm];
  longint sh_grad [MaxEm];
  longint sh_frac [MaxEm];

  nus_pkg::nus_out_t unmix_q [$];   // expected fractions and RMSE beats, oldest first
  nus_pkg::nus_in_t  beat_q  [$];   // input beats waiting for the driver

  int  err_cnt = 0;
  bit  no_gaps = 1'b0;     // driver idles at random unless set

  function automatic longint clip_grad(longint v);
    if (v > GradHi) return GradHi;
    if (v < GradLo) return GradLo;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Gram + correlation, clamped coordinate descent, then residual RMSE.
  function automatic void unmix_pixel(int nem, int nb);
    longint prev [MaxEm];
    longint acc, g, diag, t, delta, pred, diff, mag, df, maxd;
    longint unsigned sum, rms;
    int sweeps;
    nus_pkg::nus_out_t r;
    for (int i = 0; i < nem; i++) begin
      for (int j = 0; j < nem; j++) begin
        g = 0;
        for (int b = 0; b < nb; b++)
          g += sh_coef[i*MaxBands+b] * sh_coef[j*MaxBands+b];
        sh_gram[i][j] = g;
      end
      acc = 0;
      for (int b = 0; b < nb; b++) acc += sh_coef[i*MaxBands+b] * sh_pix[b];
      sh_grad[i] = clip_grad(-acc);
      sh_frac[i] = 0;
    end
    sweeps = 0;
    forever begin
      maxd = 0;
      if (sweeps >= int'(sh_limit)) break;
      for (int i = 0; i < nem; i++) prev[i] = sh_frac[i];
      for (int i = 0; i < nem; i++) begin
        diag = sh_gram[i][i];
        if (diag <= 0) continue;  // zero diagonal: coordinate left alone
        t = sh_frac[i] - (sh_grad[i] * 4096) / diag;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        delta = t - sh_frac[i];
        if (delta != 0)
          for (int j = 0; j < nem; j++)
            sh_grad[j] = clip_grad(sh_grad[j] + (delta * sh_gram[i][j]) / 4096);
        sh_frac[i] = t;
      end
      for (int i = 0; i < nem; i++) begin
        df = sh_frac[i] > prev[i] ? sh_frac[i] - prev[i] : prev[i] - sh_frac[i];
        if (df > maxd) maxd = df;
      end
      sweeps = (sweeps + 1) & 16'hFFFF;
      if (maxd <= longint'(sh_tol)) break;
    end
    sum = 0;
    for (int b = 0; b < nb; b++) begin
      pred = 0;
      for (int i = 0; i < nem; i++) pred += sh_frac[i] * sh_coef[i*MaxBands+b];
      diff = pred - sh_pix[b] * 4096;
      mag = diff < 0 ? -diff : diff;
      mag = (mag + 2048) >>> 12;
      sum += longint'(mag) * longint'(mag);
    end
    rms = floor_sqrt(sum / nb);
    for (int k = 0; k < nem; k++) begin
      r.result_kind   = nus_pkg::RES_FRAC;
      r.result_index  = k[nus_pkg::EmW-1:0];
      r.result_value  = sh_frac[k][nus_pkg::FracW-1:0];
      r.last_of_pixel = 1'b0;
      unmix_q.push_back(r);
    end
    r.result_kind   = nus_pkg::RES_RMSE;
    r.result_index  = '0;
    r.result_value  = rms > 65535 ? 16'hFFFF : rms[nus_pkg::FracW-1:0];
    r.last_of_pixel = 1'b1;
    unmix_q.push_back(r);
  endfunction

  function automatic void absorb_beat(nus_pkg::nus_in_t b);
    int nem, nb;
    longint v;
    nem = int'(sh_nem);
    nb  = int'(sh_nb);
    if (nem < 1) nem = 1;
    if (nem > MaxEm) nem = MaxEm;
    if (nb < 1) nb = 1;
    if (nb > MaxBands) nb = MaxBands;
    v = longint'($signed(b.sample_value));
    if (b.mode == nus_pkg::MODE_LOAD) begin
      sh_coef[int'(b.endmember_index)*MaxBands + int'(b.band_index)] = v;
      return;
    end
    sh_pix[b.band_index] = v;
    // only the last band in use kicks off a solve
    if (int'(b.band_index) == nb - 1) unmix_pixel(nem, nb);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds beats from beat_q; holds a beat while the block is busy.
  // Also mirrors accepted register writes into the shadow registers.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (nus_pkg::cfg_idx_e'(cfg_index_i))
          nus_pkg::CFG_LIMIT: sh_limit <= cfg_data_i[nus_pkg::LimitW-1:0];
          nus_pkg::CFG_TOL:   sh_tol   <= cfg_data_i[nus_pkg::TolW-1:0];
          nus_pkg::CFG_NEM:   sh_nem   <= cfg_data_i[nus_pkg::NemCfgW-1:0];
          nus_pkg::CFG_NB:    sh_nb    <= cfg_data_i[nus_pkg::NbCfgW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) absorb_beat(in_i);
      if (!(start_i && busy_o)) begin
        if (beat_q.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
          start_i <= 1'b1;
          in_i    <= beat_q.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (unmix_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxErrShown)
          $display("ERROR: unexpected result beat kind=%0d idx=%0d val=%0d last=%0d",
                   res_o.result_kind, res_o.result_index, res_o.result_value,
                   res_o.last_of_pixel);
      end else begin
        nus_pkg::nus_out_t e;
        e = unmix_q.pop_front();
        if (res_o.result_kind !== e.result_kind || res_o.result_index !== e.result_index ||
            res_o.result_value !== e.result_value ||
            res_o.last_of_pixel !== e.last_of_pixel) begin
          err_cnt++;
          if (err_cnt <= MaxErrShown)
            $display("ERROR: exp kind=%0d idx=%0d val=%0d last=%0d, got %0d %0d %0d %0d",
                     e.result_kind, e.result_index, e.result_value, e.last_of_pixel,
                     res_o.result_kind, res_o.result_index, res_o.result_value,
                     res_o.last_of_pixel);
        end
      end
    end
  end

  // Watchdog
  int cyc = 0;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Tracks which store entries were written so that no solve ever
  // reads a coefficient or sample that was never loaded.
  // ---------------------------------------------------------------------------
  bit gen_coef_ok [MaxEm*MaxBands];
  bit gen_pix_ok  [MaxBands];
  int gen_nem = MaxEm, gen_nb = MaxBands;
  int rnd_items = 0;

  task automatic cfg_write(nus_pkg::cfg_idx_e idx, int val);
    int v;
    v = val;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v[15:0];
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // write all four registers; clamped copies steer the generator
  task automatic set_mode(int lim, int tol, int nem, int nb);
    cfg_write(nus_pkg::CFG_LIMIT, lim);
    cfg_write(nus_pkg::CFG_TOL, tol);
    cfg_write(nus_pkg::CFG_NEM, nem);
    cfg_write(nus_pkg::CFG_NB, nb);
    gen_nem = nem < 1 ? 1 : (nem > MaxEm ? MaxEm : nem);
    gen_nb  = nb < 1 ? 1 : (nb > MaxBands ? MaxBands : nb);
  endtask

  task automatic put_beat(nus_pkg::mode_e m, int em, int band, int val);
    nus_pkg::nus_in_t b;
    b.mode            = m;
    b.endmember_index = em[nus_pkg::EmW-1:0];
    b.band_index      = band[nus_pkg::BandW-1:0];
    b.sample_value    = val[nus_pkg::SmpW-1:0];
    if (m == nus_pkg::MODE_LOAD) gen_coef_ok[em*MaxBands+band] = 1'b1;
    else gen_pix_ok[band] = 1'b1;
    beat_q.push_back(b);
    rnd_items++;
  endtask

  // fill any coefficient or sample the next solve would read but never got
  task automatic fill_gaps();
    for (int i = 0; i < gen_nem; i++)
      for (int b = 0; b < gen_nb; b++)
        if (!gen_coef_ok[i*MaxBands+b])
          put_beat(nus_pkg::MODE_LOAD, i, b, $urandom_range(65535));
    for (int b = 0; b < gen_nb - 1; b++)
      if (!gen_pix_ok[b]) put_beat(nus_pkg::MODE_PIXEL, 0, b, $urandom_range(65535));
  endtask

  // whole pixel: bands in random order, last band in use at the end
  task automatic put_pixel();
    int ord [$];
    for (int b = 0; b < gen_nb - 1; b++) ord.push_back(b);
    ord.shuffle();
    fill_gaps();
    foreach (ord[k])
      put_beat(nus_pkg::MODE_PIXEL, $urandom_range(7), ord[k], $urandom_range(65535));
    put_beat(nus_pkg::MODE_PIXEL, $urandom_range(7), gen_nb - 1, $urandom_range(65535));
  endtask

  // block is idle: nothing queued, nothing owed, plus a margin for loads
  task automatic drain();
    while (beat_q.size() != 0 || unmix_q.size() != 0 || start_i || busy_o)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int pick, em, band;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // zero iteration limit: all fractions stay zero
    set_mode(0, 0, 2, 2);
    put_beat(nus_pkg::MODE_LOAD, 0, 0, 32767);
    put_beat(nus_pkg::MODE_LOAD, 0, 1, -32768);
    put_beat(nus_pkg::MODE_LOAD, 1, 0, 4096);
    put_beat(nus_pkg::MODE_LOAD, 1, 1, 0);
    put_beat(nus_pkg::MODE_LOAD, 7, 15, -1);
    put_beat(nus_pkg::MODE_PIXEL, 7, 15, 12345);     // beyond bands in use: stored only
    put_beat(nus_pkg::MODE_PIXEL, 0, 0, -32768);
    put_beat(nus_pkg::MODE_PIXEL, 0, 1, 32767);
    drain();

    // huge limit, one endmember and band, loose tolerance ends after a sweep
    set_mode(65535, 32767, 1, 1);
    put_beat(nus_pkg::MODE_LOAD, 0, 0, 8192);
    put_beat(nus_pkg::MODE_PIXEL, 0, 0, 8000);
    drain();

    // endmember count above the maximum clamps to 8
    set_mode(3, 0, 15, 2);
    put_pixel();
    drain();

    // band count above the maximum clamps to 16
    set_mode(3, 0, 1, 31);
    put_pixel();
    drain();

    // zero Gram diagonal: endmember 1 all zero
    set_mode(5, 10, 3, 2);
    put_beat(nus_pkg::MODE_LOAD, 1, 0, 0);
    put_beat(nus_pkg::MODE_LOAD, 1, 1, 0);
    put_pixel();
    drain();

    // zero counts clamp to one endmember and one band
    set_mode(2, 0, 0, 0);
    put_beat(nus_pkg::MODE_PIXEL, 3, 0, 4096);
    drain();

    // random phases; one runs without driver gaps
    for (int ph = 0; rnd_items < 130 || ph < 2; ph++) begin
      no_gaps = (ph == 1);
      set_mode($urandom_range(12, 1), $urandom_range(300), $urandom_range(8, 1),
               $urandom_range(8, 1));
      for (int n = 0; n < 6; n++) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          if ($urandom_range(9) == 0) begin
            em = $urandom_range(gen_nem - 1);
            for (int b = 0; b < gen_nb; b++) put_beat(nus_pkg::MODE_LOAD, em, b, 0);
          end else begin
            repeat ($urandom_range(3))
              put_beat(nus_pkg::MODE_LOAD, $urandom_range(gen_nem - 1),
                       $urandom_range(gen_nb - 1), $urandom_range(65535));
          end
          put_pixel();
        end else if (pick < 85) begin
          put_beat(nus_pkg::MODE_LOAD, $urandom_range(7), $urandom_range(15),
                   $urandom_range(65535));
        end else begin
          // stray pixel sample; fill gaps first in case it hits the last band
          band = $urandom_range(15);
          if (band == gen_nb - 1) fill_gaps();
          put_beat(nus_pkg::MODE_PIXEL, $urandom_range(7), band, $urandom_range(65535));
        end
      end
      drain();
    end
    no_gaps = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### nnls_unmixing_solver.f
hw/rtl/nus_pkg.sv
hw/rtl/nus_ram.sv
hw/rtl/nus_div.sv
hw/rtl/nnls_unmixing_solver.sv
tb/tb_nnls_unmixing_solver.sv
